// File: src/imap_banner_starttls_parser_top_defines.svh
// Assertion macros for the IMAP banner/STARTTLS parser.
// No dependencies; included inside modules that have clk and rst in scope.
`ifndef IMAP_BANNER_STARTTLS_PARSER_TOP_DEFINES_SVH
`define IMAP_BANNER_STARTTLS_PARSER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IBSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ibsp_pkg.sv
// Shared constants for the IMAP banner/STARTTLS parser: action codes and
// the protocol characters it matches. No dependencies.
package ibsp_pkg;

  localparam int ActionWidth = 3;

  localparam logic [ActionWidth-1:0] ACT_NONE     = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_CLOSE    = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_CAPA     = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_STARTTLS = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_TLS      = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

endpackage

// File: src/imap_banner_starttls_parser_top.sv
// IMAP greeting / CAPABILITY / STARTTLS reply checker, one byte per request.
// Depends on ibsp_pkg and imap_banner_starttls_parser_top_defines.svh.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+--------------------------------------
//  rx      | rx_valid  | rx_ready  | rx_byte
//  res     | res_valid | res_ready | keep_byte, banner_byte, action, stopped
//
// One request per cycle while results are taken: the phase step and byte
// compares run between the input ports and the result register.
// rx_ready is high while the result register is empty or being taken.
// A stalled result holds the register and back-pressures rx.
// rst (synchronous) returns the phase to greeting start and empties results.
module imap_banner_starttls_parser_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rx_valid,
  output logic                              rx_ready,
  input  logic [7:0]                        rx_byte,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              keep_byte,
  output logic [7:0]                        banner_byte,
  output logic [ibsp_pkg::ActionWidth-1:0]  action,
  output logic                              stopped
);
  import ibsp_pkg::*;

  typedef enum logic [4:0] {
    PH_STAR, PH_SPACES, PH_O, PH_K, PH_GTEXT, PH_GREST,
    PH_C_TAG, PH_C_0A, PH_C_0B, PH_C_DIGIT, PH_C_SP, PH_C_REST, PH_C_SKIP,
    PH_S_TAG, PH_S_0A, PH_S_0B, PH_S_DIGIT, PH_S_SP, PH_S_REST, PH_S_SKIP,
    PH_STOP
  } phase_t;

  phase_t                 phase;
  phase_t                 phase_next;
  logic                   keep_next;
  logic [ActionWidth-1:0] action_next;
  logic                   fail;
  logic                   accept;

  assign rx_ready = !res_valid || res_ready;
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    phase_next  = phase;
    keep_next   = 1'b0;
    action_next = ACT_NONE;
    fail        = 1'b0;
    if (rx_byte != CH_CR && phase != PH_STOP) begin
      keep_next = 1'b1;
      unique case (phase)
        PH_STAR: begin
          if (rx_byte == CH_STAR) phase_next = PH_SPACES; else fail = 1'b1;
        end
        PH_SPACES: begin
          if (rx_byte != CH_SPACE) begin
            if (rx_byte == CH_O) phase_next = PH_K; else fail = 1'b1;
          end
        end
        PH_O: begin
          if (rx_byte == CH_O) phase_next = PH_K; else fail = 1'b1;
        end
        PH_K: begin
          if (rx_byte == CH_K) phase_next = PH_GTEXT; else fail = 1'b1;
        end
        PH_GTEXT: begin
          if (rx_byte == CH_SPACE) begin
            phase_next = PH_GREST;
          end else if (rx_byte == CH_LF) begin
            action_next = ACT_CAPA;
            phase_next  = PH_C_TAG;
          end
        end
        PH_GREST: begin
          if (rx_byte == CH_LF) begin
            action_next = ACT_CAPA;
            phase_next  = PH_C_TAG;
          end
        end
        PH_C_TAG: begin
          if (rx_byte == CH_STAR) phase_next = PH_C_SKIP;
          else if (rx_byte == CH_A) phase_next = PH_C_0A;
          else fail = 1'b1;
        end
        PH_S_TAG: begin
          if (rx_byte == CH_STAR) phase_next = PH_S_SKIP;
          else if (rx_byte == CH_A) phase_next = PH_S_0A;
          else fail = 1'b1;
        end
        PH_C_0A: begin
          if (rx_byte == CH_ZERO) phase_next = PH_C_0B; else fail = 1'b1;
        end
        PH_C_0B: begin
          if (rx_byte == CH_ZERO) phase_next = PH_C_DIGIT; else fail = 1'b1;
        end
        PH_S_0A: begin
          if (rx_byte == CH_ZERO) phase_next = PH_S_0B; else fail = 1'b1;
        end
        PH_S_0B: begin
          if (rx_byte == CH_ZERO) phase_next = PH_S_DIGIT; else fail = 1'b1;
        end
        PH_C_DIGIT: begin
          if (rx_byte == CH_ONE) phase_next = PH_C_SP; else fail = 1'b1;
        end
        PH_S_DIGIT: begin
          if (rx_byte == CH_TWO) phase_next = PH_S_SP; else fail = 1'b1;
        end
        PH_C_SP: begin
          if (rx_byte == CH_SPACE) phase_next = PH_C_REST; else fail = 1'b1;
        end
        PH_S_SP: begin
          if (rx_byte == CH_SPACE) phase_next = PH_S_REST; else fail = 1'b1;
        end
        PH_C_REST: begin
          if (rx_byte == CH_LF) begin
            action_next = ACT_STARTTLS;
            phase_next  = PH_S_TAG;
          end
        end
        PH_C_SKIP: begin
          if (rx_byte == CH_LF) phase_next = PH_C_TAG;
        end
        PH_S_SKIP: begin
          if (rx_byte == CH_LF) phase_next = PH_S_TAG;
        end
        PH_S_REST: begin
          keep_next = 1'b0;
          if (rx_byte == CH_LF) begin
            action_next = ACT_TLS;
            phase_next  = PH_STOP;
          end
        end
        default: begin
          keep_next  = 1'b0;
          phase_next = PH_STOP;
        end
      endcase
      if (fail) begin
        action_next = ACT_CLOSE;
        phase_next  = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STAR;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (accept) begin
      keep_byte   <= keep_next;
      banner_byte <= keep_next ? rx_byte : 8'h00;
      action      <= action_next;
      stopped     <= (phase_next == PH_STOP);
    end
  end

`include "imap_banner_starttls_parser_top_defines.svh"

  `IBSP_ASSERT_NEXT(a_stop_sticky, phase == PH_STOP, phase == PH_STOP, "stopped phase left")
  `IBSP_ASSERT_NEXT(a_accept_fills, accept, res_valid, "accepted request gave no result")
  `IBSP_ASSERT_SAME(a_tls_stops, res_valid && action == ACT_TLS, stopped && !keep_byte, "bad hand-off result")
  `IBSP_ASSERT_SAME(a_close_stops, res_valid && action == ACT_CLOSE, stopped && keep_byte, "bad close result")

endmodule
